/* rtl/core/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, constants and the CRC-4 table of the SENT frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned CHANNELS = 4;
  localparam int unsigned CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned N_ERR    = 6;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_AW   = 3;

  typedef enum logic [3:0] {
    PH_INIT   = 4'd0,
    PH_SYNC   = 4'd1,
    PH_STATUS = 4'd2,
    PH_D1     = 4'd3,
    PH_D2     = 4'd4,
    PH_D3     = 4'd5,
    PH_D4     = 4'd6,
    PH_D5     = 4'd7,
    PH_D6     = 4'd8,
    PH_CRC    = 4'd9
  } phase_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_MIN_INTERVAL = 3'd0,
    CFG_OFFSET       = 3'd1,
    CFG_SYNC_VALUE   = 3'd2,
    CFG_MAX_NIBBLE   = 3'd3,
    CFG_CRC_SEED     = 3'd4
  } cfg_reg_e;

  localparam int unsigned ERR_MIN    = 0;
  localparam int unsigned ERR_SYNC   = 1;
  localparam int unsigned ERR_STATUS = 2;
  localparam int unsigned ERR_MAX    = 3;
  localparam int unsigned ERR_ROLL   = 4;
  localparam int unsigned ERR_CRC    = 5;

  // per-channel record held in the state ram
  typedef struct packed {
    phase_e      phase;
    logic [11:0] val_asm;
    logic [3:0]  crc;
    logic [7:0]  roll_asm;
    logic [7:0]  prev_roll;
    logic [11:0] acc_val;
    logic [3:0]  status;
  } chan_rec_t;

  function automatic logic [3:0] crc4_tab(input logic [3:0] idx);
    logic [3:0] r;
    unique case (idx)
      4'd0:  r = 4'd0;
      4'd1:  r = 4'd13;
      4'd2:  r = 4'd7;
      4'd3:  r = 4'd10;
      4'd4:  r = 4'd14;
      4'd5:  r = 4'd3;
      4'd6:  r = 4'd9;
      4'd7:  r = 4'd4;
      4'd8:  r = 4'd1;
      4'd9:  r = 4'd12;
      4'd10: r = 4'd6;
      4'd11: r = 4'd11;
      4'd12: r = 4'd15;
      4'd13: r = 4'd2;
      4'd14: r = 4'd8;
      default: r = 4'd5;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/sent_frame_decoder_unit.sv */
// ----------------------------------------------------------------------------
// sent_frame_decoder_unit
// Multi-channel SENT fast-channel decoder, one pulse interval per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with channel_i and interval_ticks_i.
//   Each accepted pulse produces exactly one result transfer on the output
//   channel (out_valid_o / out_stall_i), in order of acceptance.
//   Each pulse passes the update stage register and then the output register,
//   which drives out_valid_o.
//   Throughput: one pulse per cycle while the output is not stalled. Per-channel
//   state sits in a ram with registered read data; a read is issued on acceptance,
//   the record is updated in the next cycle and written back, and a back-to-back
//   pulse on the same channel takes the record from the write-back register.
//   Configuration: cfg_we_i, cfg_idx_i, cfg_data_i, written while idle.
//   Reset: configuration returns to its defaults, error counters clear and all
//   channel records read as zero (init phase) until first written; no
//   clearing pass is needed.
//   Receiver stall: the output register holds, the update stage holds, and
//   in_stall_o rises once the update stage is occupied and cannot drain.
// ----------------------------------------------------------------------------
module sent_frame_decoder_unit
  import sfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        channel_i,
  input  logic [15:0]       interval_ticks_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        channel_out_o,
  output logic              frame_done_o,
  output logic              crc_ok_o,
  output logic [11:0]       value_o,
  output logic [7:0]        rolling_count_out_o,
  output logic [3:0]        status_nibble_o,
  output logic [15:0]       min_interval_errors_o,
  output logic [15:0]       sync_errors_o,
  output logic [15:0]       status_errors_o,
  output logic [15:0]       max_interval_errors_o,
  output logic [15:0]       rolling_errors_o,
  output logic [15:0]       crc_errors_o,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned REC_W = $bits(chan_rec_t);

  // configuration
  logic [15:0] min_int_q, offset_q, sync_val_q;
  logic [3:0]  max_nib_q, crc_seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_int_q  <= 16'd12;
      offset_q   <= 16'd12;
      sync_val_q <= 16'd44;
      max_nib_q  <= 4'd15;
      crc_seed_q <= 4'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_INTERVAL: min_int_q  <= cfg_data_i;
        CFG_OFFSET:       offset_q   <= cfg_data_i;
        CFG_SYNC_VALUE:   sync_val_q <= cfg_data_i;
        CFG_MAX_NIBBLE:   max_nib_q  <= cfg_data_i[3:0];
        CFG_CRC_SEED:     crc_seed_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // handshake and stage control
  logic             s1_valid_q;
  logic [1:0]       s1_ch_q;
  logic [15:0]      s1_raw_q;
  logic             s1_fwd_q;
  logic             s1_rvld_q;
  logic             adv;
  logic             accept;
  logic [CH_AW-1:0] in_idx;
  logic [CH_AW-1:0] s1_idx;
  logic             s1_in_range;
  logic             out_valid_q;

  assign adv         = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !adv;
  assign accept      = in_valid_i && !in_stall_o;
  assign in_idx      = CH_AW'(channel_i);
  assign s1_idx      = CH_AW'(s1_ch_q);
  assign s1_in_range = (int'(s1_ch_q) < CHANNELS);

  // state ram
  chan_rec_t        rd_rec, cur, nxt, wr_rec_q;
  logic [REC_W-1:0] rd_data;
  logic [CHANNELS-1:0] ent_vld_q;
  logic             ram_we;

  assign ram_we = adv && s1_in_range;

  sfd_ram #(
    .Width(REC_W),
    .Depth(CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_idx),
    .wdata_i (nxt),
    .re_i    (accept),
    .raddr_i (in_idx),
    .rdata_o (rd_data)
  );

  assign rd_rec = chan_rec_t'(rd_data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
      s1_rvld_q  <= 1'b0;
      ent_vld_q  <= '0;
    end else begin
      if (ram_we) begin
        ent_vld_q[s1_idx] <= 1'b1;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
        s1_fwd_q   <= ram_we && (s1_idx == in_idx);
        s1_rvld_q  <= ent_vld_q[in_idx];
      end else if (adv) begin
        s1_valid_q <= 1'b0;
        s1_fwd_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ch_q  <= channel_i;
      s1_raw_q <= interval_ticks_i;
    end
    if (ram_we) begin
      wr_rec_q <= nxt;
    end
  end

  // record update
  logic [15:0]      err_q [N_ERR];
  logic [15:0]      err_d [N_ERR];
  logic [N_ERR-1:0] inc;
  logic [15:0]      v;
  logic [3:0]       nib;
  logic             done, ok;

  always_comb begin
    if (s1_fwd_q) begin
      cur = wr_rec_q;
    end else if (s1_rvld_q) begin
      cur = rd_rec;
    end else begin
      cur = '0;
    end
    nxt  = cur;
    inc  = '0;
    done = 1'b0;
    ok   = 1'b0;
    v    = s1_raw_q - offset_q;
    nib  = v[3:0];
    if (s1_raw_q < min_int_q) begin
      inc[ERR_MIN] = 1'b1;
      nxt.phase    = PH_SYNC;
    end else if (cur.phase == PH_INIT || cur.phase == PH_SYNC) begin
      if (v == sync_val_q) begin
        nxt.val_asm = '0;
        nxt.phase   = PH_STATUS;
      end else if (cur.phase == PH_SYNC) begin
        inc[ERR_SYNC] = 1'b1;
      end
    end else if (v > {12'd0, max_nib_q}) begin
      inc[ERR_MAX] = 1'b1;
      nxt.phase    = PH_SYNC;
    end else begin
      unique case (cur.phase)
        PH_STATUS: begin
          nxt.status      = nib;
          inc[ERR_STATUS] = (nib != 4'd0);
        end
        PH_D1: begin
          nxt.crc     = nib ^ crc4_tab(crc_seed_q);
          nxt.val_asm = {nib, 8'd0};
        end
        PH_D2: begin
          nxt.crc     = nib ^ crc4_tab(cur.crc);
          nxt.val_asm = cur.val_asm | {4'd0, nib, 4'd0};
        end
        PH_D3: begin
          nxt.crc     = nib ^ crc4_tab(cur.crc);
          nxt.val_asm = cur.val_asm | {8'd0, nib};
        end
        PH_D4: begin
          nxt.crc      = nib ^ crc4_tab(cur.crc);
          nxt.roll_asm = {nib, 4'd0};
        end
        PH_D5: begin
          nxt.crc      = nib ^ crc4_tab(cur.crc);
          nxt.roll_asm = cur.roll_asm | {4'd0, nib};
        end
        PH_D6: begin
          nxt.crc = nib ^ crc4_tab(cur.crc);
        end
        default: begin
          done          = 1'b1;
          inc[ERR_ROLL] = (cur.roll_asm != (cur.prev_roll + 8'd1));
          nxt.prev_roll = cur.roll_asm;
          if (nib == crc4_tab(cur.crc)) begin
            ok          = 1'b1;
            nxt.acc_val = cur.val_asm;
          end else begin
            inc[ERR_CRC] = 1'b1;
          end
        end
      endcase
      if (cur.phase >= PH_CRC) begin
        nxt.phase = PH_SYNC;
      end else begin
        nxt.phase = phase_e'(cur.phase + 4'd1);
      end
    end
    for (int i = 0; i < N_ERR; i++) begin
      if (s1_in_range && inc[i] && (err_q[i] != 16'hFFFF)) begin
        err_d[i] = err_q[i] + 16'd1;
      end else begin
        err_d[i] = err_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_ERR; i++) begin
        err_q[i] <= '0;
      end
    end else if (adv) begin
      err_q <= err_d;
    end
  end

  // output register
  logic [1:0]  out_ch_q;
  logic        out_done_q, out_ok_q;
  logic [11:0] out_val_q;
  logic [7:0]  out_roll_q;
  logic [3:0]  out_stat_q;
  logic [15:0] out_err_q [N_ERR];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ch_q   <= s1_ch_q;
      out_done_q <= s1_in_range && done;
      out_ok_q   <= s1_in_range && ok;
      out_val_q  <= s1_in_range ? nxt.acc_val : 12'd0;
      out_roll_q <= s1_in_range ? nxt.prev_roll : 8'd0;
      out_stat_q <= s1_in_range ? nxt.status : 4'd0;
      out_err_q  <= err_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign channel_out_o         = out_ch_q;
  assign frame_done_o          = out_done_q;
  assign crc_ok_o              = out_ok_q;
  assign value_o               = out_val_q;
  assign rolling_count_out_o   = out_roll_q;
  assign status_nibble_o       = out_stat_q;
  assign min_interval_errors_o = out_err_q[ERR_MIN];
  assign sync_errors_o         = out_err_q[ERR_SYNC];
  assign status_errors_o       = out_err_q[ERR_STATUS];
  assign max_interval_errors_o = out_err_q[ERR_MAX];
  assign rolling_errors_o      = out_err_q[ERR_ROLL];
  assign crc_errors_o          = out_err_q[ERR_CRC];

  // assertions
  a_stall_needs_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked update stage");

  a_fwd_needs_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fwd_q |-> s1_valid_q)
    else $error("forwarding flag set with no item in the update stage");

  a_ok_needs_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ok_q) |-> out_done_q)
    else $error("crc ok reported without a completed frame");

  a_min_err_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (err_q[ERR_MIN] >= $past(err_q[ERR_MIN])))
    else $error("min interval error counter decreased");

  a_crc_err_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (err_q[ERR_CRC] >= $past(err_q[ERR_CRC])))
    else $error("crc error counter decreased");

endmodule

/* rtl/core/sfd_ram.sv */
// ----------------------------------------------------------------------------
// sfd_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
module sfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
